@@ rtl/sscf_pkg.sv @@
// Shared types and constants for the servo status frame checker.
`timescale 1ns / 1ps
`default_nettype none

package sscf_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ErrW     = 16;
  localparam int unsigned PosW     = 9;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned OutDataW = 24;

  // Output queue geometry.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  localparam logic [ByteW-1:0] HdrByte   = 8'hFF;
  localparam logic [ByteW-1:0] CntMax    = 8'hFF;
  localparam logic [ByteW-1:0] ExpIdRst  = 8'd1;
  localparam logic [ByteW-1:0] ExpLenRst = 8'd0;

  // Byte positions inside a frame.
  localparam logic [ByteW-1:0] PosIdByte  = 8'd2;
  localparam logic [ByteW-1:0] PosErrByte = 8'd4;
  localparam logic [ByteW-1:0] PosPayload = 8'd5;
  localparam logic [PosW-1:0]  ChkBase    = 9'd5;
  localparam logic [PosW-1:0]  FrameFixed = 9'd6;

  localparam logic [ErrW-1:0] ErrNoReply  = 16'hFFFF;
  localparam logic [ErrW-1:0] ErrCount    = 16'h0100;
  localparam logic [ErrW-1:0] ErrHeader   = 16'h0200;
  localparam logic [ErrW-1:0] ErrId       = 16'h0400;
  localparam logic [ErrW-1:0] ErrChecksum = 16'h0800;

  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgIdxExpId  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxExpLen = 8'd1;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] payload;
    logic [ErrW-1:0]  err;
    logic             last;
  } result_t;

  // Up to two results produced by one accepted item, first in r0.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

endpackage

`default_nettype wire

@@ rtl/sscf_frame.sv @@
// Frame state tracking and result generation for one accepted byte item.
`timescale 1ns / 1ps
`default_nettype none

module sscf_frame (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_fire,
  input  wire logic [sscf_pkg::ByteW-1:0] rx_byte,
  input  wire logic                      frame_end,
  input  wire logic                      no_reply,
  input  wire logic [sscf_pkg::ByteW-1:0] expected_id,
  input  wire logic [sscf_pkg::ByteW-1:0] expected_len,
  output sscf_pkg::result_pair_t         results
);

  logic [sscf_pkg::ByteW-1:0] cnt_r, cnt_nxt, tk_cnt;
  logic [sscf_pkg::ByteW-1:0] sum_r, sum_nxt, tk_sum;
  logic                       hdr_bad_r, hdr_bad_nxt, tk_hdr_bad;
  logic                       id_bad_r, id_bad_nxt, tk_id_bad;
  logic [sscf_pkg::ByteW-1:0] serr_r, serr_nxt, tk_serr;
  logic [sscf_pkg::ByteW-1:0] rchk_r, rchk_nxt, tk_rchk;

  logic [sscf_pkg::PosW-1:0]  chk_pos;
  logic [sscf_pkg::PosW-1:0]  pos_ext;
  logic                       payload_hit;
  logic                       status_hit;
  logic [sscf_pkg::ErrW-1:0]  err;
  sscf_pkg::result_t          pay_res;
  sscf_pkg::result_t          st_res;

  always_comb begin
    chk_pos     = sscf_pkg::ChkBase + {1'b0, expected_len};
    pos_ext     = {1'b0, cnt_r};
    tk_cnt      = cnt_r;
    tk_sum      = sum_r;
    tk_hdr_bad  = hdr_bad_r;
    tk_id_bad   = id_bad_r;
    tk_serr     = serr_r;
    tk_rchk     = rchk_r;
    payload_hit = 1'b0;
    status_hit  = 1'b0;

    if (in_fire) begin
      // A byte that arrives at a saturated count is ignored and the count stays put.
      if (!no_reply && cnt_r != sscf_pkg::CntMax) begin
        tk_cnt = cnt_r + 8'd1;
        if (cnt_r < sscf_pkg::PosIdByte) begin
          if (rx_byte != sscf_pkg::HdrByte) begin
            tk_hdr_bad = 1'b1;
          end
        end else if (cnt_r < sscf_pkg::PosPayload) begin
          tk_sum = sum_r + rx_byte;
          if (cnt_r == sscf_pkg::PosIdByte && rx_byte != expected_id) begin
            tk_id_bad = 1'b1;
          end
          if (cnt_r == sscf_pkg::PosErrByte) begin
            tk_serr = rx_byte;
          end
        end else if (pos_ext < chk_pos) begin
          tk_sum      = sum_r + rx_byte;
          payload_hit = 1'b1;
        end else if (pos_ext == chk_pos) begin
          tk_rchk = rx_byte;
        end
      end
      status_hit = no_reply | frame_end;
    end

    // Status is judged on the state after this item's byte was taken.
    if (tk_cnt == '0) begin
      err = sscf_pkg::ErrNoReply;
    end else begin
      err = {8'h00, tk_serr};
      if ({1'b0, tk_cnt} != sscf_pkg::FrameFixed + {1'b0, expected_len}) begin
        err = err | sscf_pkg::ErrCount;
      end
      if (tk_hdr_bad || tk_cnt < sscf_pkg::PosIdByte) begin
        err = err | sscf_pkg::ErrHeader;
      end
      if (tk_id_bad || (tk_cnt <= sscf_pkg::PosIdByte && expected_id != '0)) begin
        err = err | sscf_pkg::ErrId;
      end
      if (~tk_sum != tk_rchk) begin
        err = err | sscf_pkg::ErrChecksum;
      end
    end

    if (status_hit) begin
      cnt_nxt     = '0;
      sum_nxt     = '0;
      hdr_bad_nxt = 1'b0;
      id_bad_nxt  = 1'b0;
      serr_nxt    = '0;
      rchk_nxt    = '0;
    end else begin
      cnt_nxt     = tk_cnt;
      sum_nxt     = tk_sum;
      hdr_bad_nxt = tk_hdr_bad;
      id_bad_nxt  = tk_id_bad;
      serr_nxt    = tk_serr;
      rchk_nxt    = tk_rchk;
    end

    pay_res.kind    = sscf_pkg::KindPayload;
    pay_res.payload = rx_byte;
    pay_res.err     = '0;
    pay_res.last    = 1'b0;
    st_res.kind     = sscf_pkg::KindStatus;
    st_res.payload  = '0;
    st_res.err      = err;
    st_res.last     = 1'b1;

    results.r0 = payload_hit ? pay_res : st_res;
    results.r1 = st_res;
    results.n  = {1'b0, payload_hit} + {1'b0, status_hit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      sum_r     <= '0;
      hdr_bad_r <= 1'b0;
      id_bad_r  <= 1'b0;
      serr_r    <= '0;
      rchk_r    <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      hdr_bad_r <= hdr_bad_nxt;
      id_bad_r  <= id_bad_nxt;
      serr_r    <= serr_nxt;
      rchk_r    <= rchk_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sscf_outq.sv @@
// Small result queue that takes up to two results per cycle and gives out one.
`timescale 1ns / 1ps
`default_nettype none

module sscf_outq (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire sscf_pkg::result_pair_t push,
  output logic                        space_ok,
  output logic                        head_valid,
  input  wire logic                   head_ready,
  output sscf_pkg::result_t           head
);

  sscf_pkg::result_t                q_r [sscf_pkg::QDepth];
  logic [sscf_pkg::QPtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [sscf_pkg::QPtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [sscf_pkg::QCntW-1:0]       cnt_r, cnt_nxt;
  logic                             pop;

  always_comb begin
    head_valid = (cnt_r != '0);
    head       = q_r[rd_ptr_r];
    // Room for a full pair is required before the next item is taken.
    space_ok   = (cnt_r <= sscf_pkg::QCntW'(sscf_pkg::QDepth - 2));
    pop        = head_valid & head_ready;
    wr_ptr_nxt = wr_ptr_r + push.n[sscf_pkg::QPtrW-1:0];
    rd_ptr_nxt = rd_ptr_r + sscf_pkg::QPtrW'(pop);
    cnt_nxt    = cnt_r + sscf_pkg::QCntW'(push.n) - sscf_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q_r[wr_ptr_r + sscf_pkg::QPtrW'(1)] <= push.r1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/servo_status_frame_checker_top.sv @@
// Top level of the servo status frame checker.
//
// Input stream: one received byte per item in in_tdata, in_tlast marks the last
// byte of a frame, in_tuser marks a reply timeout with no byte in the item.
// Output stream: in_tuser-style kind on out_tuser (0 payload byte, 1 status),
// payload byte and 16-bit error word in out_tdata, out_tlast on each status.
// Every payload byte of a frame comes out in order; at frame end one status
// item follows with the error flags, or 0xFFFF if no byte was received.
// An accepted item's results are written into the registered result queue.
// One item is taken per cycle while in_tready is high; a byte that closes the
// frame inside the payload yields two results, which drain through a four-entry
// result queue that decouples the two sides. in_tready drops only while that
// queue lacks room for two more results, so a stalled receiver holds the input back
// once three or four results are waiting. The cfg channel is always ready and writes
// expected_id (index 0) and expected_payload_length (index 1); other indexes
// are ignored.
// Reset empties the queue, clears the frame state and sets expected_id to 1
// and expected_payload_length to 0.
`timescale 1ns / 1ps
`default_nettype none

module servo_status_frame_checker_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,  // [7:0] rx_byte
  input  wire logic                          in_tlast,  // frame_end
  input  wire logic                          in_tuser,  // no_reply
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [sscf_pkg::OutDataW-1:0]      out_tdata, // [7:0] payload_byte, [23:8] error_word
  output logic                               out_tlast, // last
  output logic                               out_tuser, // result_kind
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sscf_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [sscf_pkg::ByteW-1:0]    cfg_data
);

  logic [sscf_pkg::ByteW-1:0] exp_id_r, exp_id_nxt;
  logic [sscf_pkg::ByteW-1:0] exp_len_r, exp_len_nxt;
  logic                       in_fire;
  logic                       space_ok;
  sscf_pkg::result_pair_t     pair;
  sscf_pkg::result_t          head;

  assign cfg_ready = 1'b1;
  assign in_tready = space_ok;
  assign in_fire   = in_tvalid & in_tready;

  always_comb begin
    exp_id_nxt  = exp_id_r;
    exp_len_nxt = exp_len_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == sscf_pkg::CfgIdxExpId) begin
        exp_id_nxt = cfg_data;
      end else if (cfg_index == sscf_pkg::CfgIdxExpLen) begin
        exp_len_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r  <= sscf_pkg::ExpIdRst;
      exp_len_r <= sscf_pkg::ExpLenRst;
    end else begin
      exp_id_r  <= exp_id_nxt;
      exp_len_r <= exp_len_nxt;
    end
  end

  sscf_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .rx_byte      (in_tdata),
    .frame_end    (in_tlast),
    .no_reply     (in_tuser),
    .expected_id  (exp_id_r),
    .expected_len (exp_len_r),
    .results      (pair)
  );

  sscf_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (pair),
    .space_ok   (space_ok),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .head       (head)
  );

  assign out_tdata = {head.err, head.payload};
  assign out_tlast = head.last;
  assign out_tuser = head.kind;

endmodule

`default_nettype wire
